@@ sv/tmsg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmsg_pkg
// Shared types, constants and the arctangent table of the turn-and-move
// setpoint generator.
// ----------------------------------------------------------------------------
package tmsg_pkg;

    localparam int ZW       = 26;  // fine angle width, 1/32768 degree
    localparam int ANGLE_W  = 16;
    localparam int STEP_W   = 15;
    localparam int QUAT_W   = 16;
    localparam int CFG_IW   = 3;
    localparam int ATAN_LEN = 24;

    localparam int HALF_TURN    = 23040;
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int FINE_HALF    = 5898240;
    localparam int FINE_QUARTER = 2949120;
    localparam int GAIN_Q30     = 652032874;
    localparam int ONE_METRE    = 4096;
    localparam int Q14_ONE      = 16384;
    localparam int GOAL_XY_RST  = 8192;
    localparam int GOAL_Z_RST   = 4096;
    localparam int STEP_RST     = 3840;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [CFG_IW-1:0] {
        CFG_END_ANGLE  = 3'd0,
        CFG_ANGLE_STEP = 3'd1,
        CFG_GOAL_X     = 3'd2,
        CFG_GOAL_Y     = 3'd3,
        CFG_GOAL_Z     = 3'd4
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic head_go;
        logic setup;
        logic mul;
        logic div_go;
        logic store_step;
        logic axis_y;
        logic advance;
        logic rot_go;
        logic rot_half;
        logic keep_offset;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_tick;
        logic running;
        logic cordic_done;
        logic div_done;
    } t_stat;

    // atan(2^-i) in 1/32768 degree
    function automatic logic [22:0] fine_atan(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:  v = 23'd1474560;
            5'd1:  v = 23'd870484;
            5'd2:  v = 23'd459940;
            5'd3:  v = 23'd233473;
            5'd4:  v = 23'd117189;
            5'd5:  v = 23'd58652;
            5'd6:  v = 23'd29333;
            5'd7:  v = 23'd14667;
            5'd8:  v = 23'd7334;
            5'd9:  v = 23'd3667;
            5'd10: v = 23'd1833;
            5'd11: v = 23'd917;
            5'd12: v = 23'd458;
            5'd13: v = 23'd229;
            5'd14: v = 23'd115;
            5'd15: v = 23'd57;
            5'd16: v = 23'd29;
            5'd17: v = 23'd14;
            5'd18: v = 23'd7;
            5'd19: v = 23'd4;
            5'd20: v = 23'd2;
            5'd21: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ sv/tmsg_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmsg_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module tmsg_cordic #(
    parameter int CW   = 44,
    parameter int ZW   = 26,
    parameter int ITER = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_vec,
    input  wire logic signed [CW-1:0] i_x,
    input  wire logic signed [CW-1:0] i_y,
    input  wire logic signed [ZW-1:0] i_z,
    output logic signed [CW-1:0]      o_x,
    output logic signed [CW-1:0]      o_y,
    output logic signed [ZW-1:0]      o_z,
    output logic                      o_done
);
    localparam int IW = $clog2(ITER);

    logic              r_busy, r_vec, r_done;
    logic [IW-1:0]     r_iter;
    logic signed [CW-1:0] r_x, r_y, xs, ys;
    logic signed [ZW-1:0] r_z, w_atan;
    logic              w_cw;

    always_comb begin
        xs     = r_x >>> r_iter;
        ys     = r_y >>> r_iter;
        w_atan = $signed({{(ZW-23){1'b0}}, tmsg_pkg::fine_atan(5'(r_iter))});
        w_cw   = r_vec ? !r_y[CW-1] : r_z[ZW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == IW'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_vec <= i_vec;
        end else if (r_busy) begin
            if (w_cw) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - w_atan;
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_done = r_done;
endmodule
`default_nettype wire

@@ sv/tmsg_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmsg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmsg_div #(
    parameter int NW = 39,
    parameter int DW = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic [NW-1:0]      o_quo,
    output logic               o_done
);
    localparam int KW = $clog2(NW + 1);

    logic          r_busy, r_done;
    logic [KW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem, r_den;
    logic [DW:0]   w_sh, w_trial;

    always_comb begin
        w_sh    = {r_rem, r_quo[NW-1]};
        w_trial = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == KW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_trial[DW]) begin
                r_rem <= w_trial[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule
`default_nettype wire

@@ sv/tmsg_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmsg_dp
// Datapath: settings, run state, shared CORDIC and divider, result register.
// ----------------------------------------------------------------------------
module tmsg_dp #(
    parameter int POS_WIDTH       = 24,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tmsg_pkg::t_cmd                i_cmd,
    output tmsg_pkg::t_stat                    o_stat,
    input  wire logic                          i_cfg_we,
    input  wire logic [tmsg_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [POS_WIDTH-1:0]          i_cfg_data,
    input  wire logic                          i_op,
    input  wire logic signed [POS_WIDTH-1:0]   i_first_x,
    input  wire logic signed [POS_WIDTH-1:0]   i_first_y,
    input  wire logic signed [POS_WIDTH-1:0]   i_second_x,
    input  wire logic signed [POS_WIDTH-1:0]   i_second_y,
    output logic signed [POS_WIDTH-1:0]        o_agent_one_x,
    output logic signed [POS_WIDTH-1:0]        o_agent_one_y,
    output logic signed [POS_WIDTH-1:0]        o_agent_two_x,
    output logic signed [POS_WIDTH-1:0]        o_agent_two_y,
    output logic signed [POS_WIDTH-1:0]        o_height,
    output logic signed [15:0]                 o_one_quat_z,
    output logic signed [15:0]                 o_one_quat_w,
    output logic signed [15:0]                 o_two_quat_z,
    output logic signed [15:0]                 o_two_quat_w,
    output logic signed [15:0]                 o_current_angle,
    output logic                               o_finished
);
    localparam int P  = POS_WIDTH;
    localparam int CW = POS_WIDTH + 20;
    localparam int NW = POS_WIDTH + 15;
    localparam int SW = tmsg_pkg::STEP_W;
    localparam int ZW = tmsg_pkg::ZW;

    function automatic logic signed [P-1:0] sat_p(input logic signed [P:0] v);
        logic signed [P-1:0] r;
        if (v[P] != v[P-1]) r = v[P] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
        else r = v[P-1:0];
        return r;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        logic signed [15:0]   q;
        r = (v + CW'(32768)) >>> 16;
        if (r > CW'(tmsg_pkg::Q14_ONE)) q = 16'(tmsg_pkg::Q14_ONE);
        else if (r < -CW'(tmsg_pkg::Q14_ONE)) q = -16'(tmsg_pkg::Q14_ONE);
        else q = r[15:0];
        return q;
    endfunction

    // settings
    logic signed [15:0]   r_end_angle;
    logic [SW-1:0]        r_angle_step;
    logic signed [P-1:0]  r_goal_x, r_goal_y, r_goal_z;

    // latched item
    logic                 r_op_tick;
    logic signed [P:0]    r_dx, r_dy;
    logic signed [P-1:0]  r_mid_x, r_mid_y;

    // run state
    logic                 r_running, r_turn_neg, r_done;
    logic signed [15:0]   r_angle;
    logic [SW-1:0]        r_turn;
    logic signed [P-1:0]  r_cx, r_cy, r_stx, r_sty;
    logic [1:0]           r_sense;
    logic signed [P:0]    r_offx, r_offy;
    logic [NW-1:0]        r_num;
    logic                 r_rot_neg;
    logic signed [13:0]   r_ox, r_oy;

    // cordic / divider
    logic                 w_c_start;
    logic signed [CW-1:0] w_cx0, w_cy0, w_cx, w_cy;
    logic signed [ZW-1:0] w_cz0, w_cz;
    logic                 w_c_done;
    logic [NW-1:0]        w_quo;
    logic                 w_d_done;

    // prep
    logic signed [CW-1:0] hx, hy;
    logic signed [ZW-1:0] hz, rz;
    logic                 rneg, dy_pos;

    always_comb begin
        hx     = {{3{r_dx[P]}}, r_dx, 16'b0};
        hy     = {{3{r_dy[P]}}, r_dy, 16'b0};
        hz     = '0;
        dy_pos = !r_dy[P] && (r_dy != '0);
        if (r_dx[P]) begin
            hz = dy_pos ? ZW'(tmsg_pkg::FINE_HALF) : -ZW'(tmsg_pkg::FINE_HALF);
            hx = -hx;
            hy = -hy;
        end
        rz   = {{(ZW-16){r_angle[15]}}, r_angle};
        rz   = i_cmd.rot_half ? (rz <<< 7) : (rz <<< 8);
        rneg = 1'b0;
        if (rz > ZW'(tmsg_pkg::FINE_QUARTER)) begin
            rz   = rz - ZW'(tmsg_pkg::FINE_HALF);
            rneg = 1'b1;
        end else if (rz < -ZW'(tmsg_pkg::FINE_QUARTER)) begin
            rz   = rz + ZW'(tmsg_pkg::FINE_HALF);
            rneg = 1'b1;
        end
        w_c_start = i_cmd.head_go | i_cmd.rot_go;
        w_cx0 = i_cmd.head_go ? hx : CW'(tmsg_pkg::GAIN_Q30);
        w_cy0 = i_cmd.head_go ? hy : '0;
        w_cz0 = i_cmd.head_go ? hz : rz;
    end

    tmsg_cordic #(.CW(CW), .ZW(ZW), .ITER(TRIG_ITERATIONS)) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_c_start),
        .i_vec  (i_cmd.head_go),
        .i_x    (w_cx0),
        .i_y    (w_cy0),
        .i_z    (w_cz0),
        .o_x    (w_cx),
        .o_y    (w_cy),
        .o_z    (w_cz),
        .o_done (w_c_done)
    );

    tmsg_div #(.NW(NW), .DW(SW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_go),
        .i_num  (r_num),
        .i_den  (r_turn),
        .o_quo  (w_quo),
        .o_done (w_d_done)
    );

    // start setup: heading, turn direction and size
    logic signed [ZW-1:0] zr;
    logic signed [15:0]   st, endw;
    logic signed [16:0]   e17;
    logic signed [17:0]   d, t18;
    logic [SW-1:0]        s_turn;
    logic                 s_neg;

    always_comb begin
        zr = (w_cz + ZW'(128)) >>> 8;
        if (r_dy == '0) st = r_dx[P] ? 16'(tmsg_pkg::HALF_TURN) : '0;
        else if (r_dx == '0) st = r_dy[P] ? -16'(tmsg_pkg::QUARTER_TURN)
                                          : 16'(tmsg_pkg::QUARTER_TURN);
        else if (zr > ZW'(tmsg_pkg::HALF_TURN)) st = 16'(tmsg_pkg::HALF_TURN);
        else if (zr < -ZW'(tmsg_pkg::HALF_TURN)) st = -16'(tmsg_pkg::HALF_TURN);
        else st = zr[15:0];
        e17 = {r_end_angle[15], r_end_angle};
        if (e17 > 17'(tmsg_pkg::HALF_TURN)) e17 = e17 - 17'(tmsg_pkg::FULL_TURN);
        else if (e17 < -17'(tmsg_pkg::HALF_TURN)) e17 = e17 + 17'(tmsg_pkg::FULL_TURN);
        endw = e17[15:0];
        d    = {{2{endw[15]}}, endw} - {{2{st[15]}}, st};
        if (d > 18'(tmsg_pkg::HALF_TURN)) begin
            s_neg = 1'b1;
            t18   = 18'(tmsg_pkg::FULL_TURN) - d;
        end else if (d >= 0) begin
            s_neg = 1'b0;
            t18   = d;
        end else if (d >= -18'(tmsg_pkg::HALF_TURN)) begin
            s_neg = 1'b1;
            t18   = -d;
        end else begin
            s_neg = 1'b0;
            t18   = d + 18'(tmsg_pkg::FULL_TURN);
        end
        s_turn = t18[SW-1:0];
    end

    // centre step
    logic signed [P:0]   off;
    logic [P:0]          mag;
    logic [P+SW:0]       prod;
    logic                big;
    logic signed [P-1:0] step_v;

    always_comb begin
        off  = i_cmd.axis_y ? r_offy : r_offx;
        mag  = off[P] ? -off : off;
        prod = mag * r_angle_step;
        big  = |w_quo[NW-1:P-1];
        if (r_turn == '0) step_v = sat_p(off);
        else if (big) step_v = off[P] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
        else step_v = off[P] ? -$signed(w_quo[P-1:0]) : $signed(w_quo[P-1:0]);
    end

    // tick advance
    logic                le;
    logic [SW-1:0]       amt;
    logic signed [17:0]  a18;
    logic signed [P:0]   vx, vy, gx, gy;
    logic signed [P-1:0] ncx, ncy;

    always_comb begin
        le  = r_turn <= r_angle_step;
        amt = le ? r_turn : r_angle_step;
        a18 = r_turn_neg ? ({{2{r_angle[15]}}, r_angle} - 18'(amt))
                         : ({{2{r_angle[15]}}, r_angle} + 18'(amt));
        if (a18 > 18'(tmsg_pkg::HALF_TURN)) a18 = a18 - 18'(tmsg_pkg::FULL_TURN);
        else if (a18 < -18'(tmsg_pkg::HALF_TURN)) a18 = a18 + 18'(tmsg_pkg::FULL_TURN);
        vx = {r_cx[P-1], r_cx} + {r_stx[P-1], r_stx};
        vy = {r_cy[P-1], r_cy} + {r_sty[P-1], r_sty};
        gx = {r_goal_x[P-1], r_goal_x};
        gy = {r_goal_y[P-1], r_goal_y};
        if (r_sense[0] ? (vx >= gx) : (vx <= gx)) vx = gx;
        if (r_sense[1] ? (vy >= gy) : (vy <= gy)) vy = gy;
        ncx = sat_p(vx);
        ncy = sat_p(vy);
    end

    // rotation results
    logic signed [CW-1:0] cc, ss, oxw, oyw;

    always_comb begin
        cc  = r_rot_neg ? -w_cx : w_cx;
        ss  = r_rot_neg ? -w_cy : w_cy;
        oxw = (cc + CW'(262144)) >>> 19;
        oyw = (ss + CW'(262144)) >>> 19;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_angle  <= '0;
            r_angle_step <= SW'(tmsg_pkg::STEP_RST);
            r_goal_x     <= P'(tmsg_pkg::GOAL_XY_RST);
            r_goal_y     <= P'(tmsg_pkg::GOAL_XY_RST);
            r_goal_z     <= P'(tmsg_pkg::GOAL_Z_RST);
            r_running    <= 1'b0;
            r_angle      <= '0;
            r_turn       <= '0;
            r_turn_neg   <= 1'b0;
            r_cx         <= '0;
            r_cy         <= '0;
            r_stx        <= '0;
            r_sty        <= '0;
            r_sense      <= '0;
            r_op_tick    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (tmsg_pkg::t_cfg_idx'(i_cfg_index))
                    tmsg_pkg::CFG_END_ANGLE:  r_end_angle  <= i_cfg_data[15:0];
                    tmsg_pkg::CFG_ANGLE_STEP: r_angle_step <= i_cfg_data[SW-1:0];
                    tmsg_pkg::CFG_GOAL_X:     r_goal_x     <= i_cfg_data;
                    tmsg_pkg::CFG_GOAL_Y:     r_goal_y     <= i_cfg_data;
                    tmsg_pkg::CFG_GOAL_Z:     r_goal_z     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_in) r_op_tick <= (tmsg_pkg::t_op'(i_op) == tmsg_pkg::OP_TICK);
            if (i_cmd.setup) begin
                r_running  <= 1'b1;
                r_angle    <= st;
                r_turn     <= s_turn;
                r_turn_neg <= s_neg;
                r_cx       <= r_mid_x;
                r_cy       <= r_mid_y;
                r_sense    <= {!r_offy[P], !r_offx[P]};
            end
            if (i_cmd.store_step) begin
                if (i_cmd.axis_y) r_sty <= step_v;
                else r_stx <= step_v;
            end
            if (i_cmd.advance) begin
                r_angle   <= a18[15:0];
                r_turn    <= le ? '0 : (r_turn - r_angle_step);
                r_running <= !le;
                r_cx      <= ncx;
                r_cy      <= ncy;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_dx    <= {i_first_x[P-1], i_first_x} - {i_second_x[P-1], i_second_x};
            r_dy    <= {i_first_y[P-1], i_first_y} - {i_second_y[P-1], i_second_y};
            r_mid_x <= P'(({i_first_x[P-1], i_first_x}
                           + {i_second_x[P-1], i_second_x}) >>> 1);
            r_mid_y <= P'(({i_first_y[P-1], i_first_y}
                           + {i_second_y[P-1], i_second_y}) >>> 1);
        end
        if (i_cmd.head_go) begin
            r_offx <= {r_goal_x[P-1], r_goal_x} - {r_mid_x[P-1], r_mid_x};
            r_offy <= {r_goal_y[P-1], r_goal_y} - {r_mid_y[P-1], r_mid_y};
        end
        if (i_cmd.mul) r_num <= NW'(prod) + NW'(r_turn) - NW'(1);
        if (i_cmd.advance) r_done <= le;
        if (i_cmd.rot_go) r_rot_neg <= rneg;
        if (i_cmd.keep_offset) begin
            r_ox <= oxw[13:0];
            r_oy <= oyw[13:0];
        end
        if (i_cmd.load_out) begin
            o_agent_one_x   <= sat_p({r_cx[P-1], r_cx} + (P+1)'(r_ox));
            o_agent_one_y   <= sat_p({r_cy[P-1], r_cy} + (P+1)'(r_oy));
            o_agent_two_x   <= sat_p({r_cx[P-1], r_cx} - (P+1)'(r_ox));
            o_agent_two_y   <= sat_p({r_cy[P-1], r_cy} - (P+1)'(r_oy));
            o_height        <= sat_p({r_goal_z[P-1], r_goal_z}
                                     + (P+1)'(tmsg_pkg::ONE_METRE));
            o_one_quat_z    <= to_q14(ss);
            o_one_quat_w    <= to_q14(cc);
            o_two_quat_z    <= -to_q14(ss);
            o_two_quat_w    <= -to_q14(cc);
            o_current_angle <= r_angle;
            o_finished      <= r_done;
        end
    end

    assign o_stat.op_tick     = r_op_tick;
    assign o_stat.running     = r_running;
    assign o_stat.cordic_done = w_c_done;
    assign o_stat.div_done    = w_d_done;
endmodule
`default_nettype wire

@@ sv/tmsg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmsg_ctrl
// Sequencer for start and tick items; owns the input ready and output valid.
// ----------------------------------------------------------------------------
module tmsg_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tmsg_pkg::t_cmd        o_cmd,
    input  wire tmsg_pkg::t_stat  i_stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_HEAD_WAIT, S_SETUP, S_MUL, S_DIV_GO, S_DIV_WAIT,
        S_ROT1_GO, S_ROT1_WAIT, S_ROT2_GO, S_ROT2_WAIT, S_OUT
    } t_state;

    t_state r_state;
    logic   r_axis, r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd             = '0;
        o_cmd.axis_y      = r_axis;
        o_cmd.load_in     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.head_go     = (r_state == S_DECODE) && !i_stat.op_tick;
        o_cmd.advance     = (r_state == S_DECODE) && i_stat.op_tick && i_stat.running;
        o_cmd.setup       = (r_state == S_SETUP);
        o_cmd.mul         = (r_state == S_MUL);
        o_cmd.div_go      = (r_state == S_DIV_GO);
        o_cmd.store_step  = (r_state == S_DIV_WAIT) && i_stat.div_done;
        o_cmd.rot_go      = (r_state == S_ROT1_GO) || (r_state == S_ROT2_GO);
        o_cmd.rot_half    = (r_state == S_ROT2_GO);
        o_cmd.keep_offset = (r_state == S_ROT1_WAIT) && i_stat.cordic_done;
        o_cmd.load_out    = (r_state == S_OUT) && w_out_free;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE:      if (i_in_valid) r_state <= S_DECODE;
                S_DECODE: begin
                    if (!i_stat.op_tick) r_state <= S_HEAD_WAIT;
                    else if (i_stat.running) r_state <= S_ROT1_GO;
                    else r_state <= S_IDLE;
                end
                S_HEAD_WAIT: if (i_stat.cordic_done) r_state <= S_SETUP;
                S_SETUP: begin
                    r_axis  <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL:       r_state <= S_DIV_GO;
                S_DIV_GO:    r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (i_stat.div_done) begin
                        r_axis  <= 1'b1;
                        r_state <= r_axis ? S_IDLE : S_MUL;
                    end
                end
                S_ROT1_GO:   r_state <= S_ROT1_WAIT;
                S_ROT1_WAIT: if (i_stat.cordic_done) r_state <= S_ROT2_GO;
                S_ROT2_GO:   r_state <= S_ROT2_WAIT;
                S_ROT2_WAIT: if (i_stat.cordic_done) r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default:     r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ sv/turn_and_move_setpoint_generator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// turn_and_move_setpoint_generator_top
// Setpoint generator for two agents carrying a rotating bar.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer. tuser[0] is the operation: start
//   (agent positions in tdata) or tick. A start sets up centre, yaw, turn
//   direction and per-tick centre step and gives no result. A tick while a
//   run is active advances yaw and centre and gives one result on m_axis;
//   an idle tick gives nothing.
//   Work: a start holds the input while it runs one CORDIC vectoring pass,
//   then one bit-serial division per axis in a shared divider. A tick runs
//   two passes of the shared CORDIC unit from its transfer to its result;
//   the next item can be taken once that result is in the output register.
//   One item is in work at a time; s_axis_tready is high only while the
//   sequencer is idle.
//   Results sit in an output register: when m_axis stalls, the next item is
//   still taken and worked on, and its result waits until the register frees.
//   Settings go through the cfg write port (index = register number) and are
//   to be written while the block is idle; the block itself does not enforce it.
//   Reset (synchronous, active low) stops any run, clears the output valid
//   and restores the settings to their defaults.
// ----------------------------------------------------------------------------
module turn_and_move_setpoint_generator_top #(
    parameter int POS_WIDTH       = 24,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // first_x, first_y, second_x, second_y
    input  wire logic [((4*POS_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  wire logic [0:0]                  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // agent_one_x, agent_one_y, agent_two_x, agent_two_y, height,
    // one_quat_z, one_quat_w, two_quat_z, two_quat_w, current_angle
    output logic [((5*POS_WIDTH+80+7)/8)*8-1:0] m_axis_tdata,
    // finished
    output logic [0:0]                       m_axis_tuser,
    input  wire logic                        i_cfg_we,
    input  wire logic [tmsg_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [POS_WIDTH-1:0]        i_cfg_data
);
    localparam int P      = POS_WIDTH;
    localparam int OUT_TW = ((5*POS_WIDTH+80+7)/8)*8;

    tmsg_pkg::t_cmd  w_cmd;
    tmsg_pkg::t_stat w_stat;

    logic signed [P-1:0] w_a1x, w_a1y, w_a2x, w_a2y, w_h;
    logic signed [15:0]  w_oqz, w_oqw, w_tqz, w_tqw, w_ang;
    logic                w_fin;

    tmsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    tmsg_dp #(.POS_WIDTH(POS_WIDTH), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (s_axis_tuser[0]),
        .i_first_x      (s_axis_tdata[P-1:0]),
        .i_first_y      (s_axis_tdata[2*P-1:P]),
        .i_second_x     (s_axis_tdata[3*P-1:2*P]),
        .i_second_y     (s_axis_tdata[4*P-1:3*P]),
        .o_agent_one_x  (w_a1x),
        .o_agent_one_y  (w_a1y),
        .o_agent_two_x  (w_a2x),
        .o_agent_two_y  (w_a2y),
        .o_height       (w_h),
        .o_one_quat_z   (w_oqz),
        .o_one_quat_w   (w_oqw),
        .o_two_quat_z   (w_tqz),
        .o_two_quat_w   (w_tqw),
        .o_current_angle(w_ang),
        .o_finished     (w_fin)
    );

    // first field in the lowest bits
    assign m_axis_tdata = OUT_TW'({w_ang, w_tqw, w_tqz, w_oqw, w_oqz,
                                   w_h, w_a2y, w_a2x, w_a1y, w_a1x});
    assign m_axis_tuser = w_fin;

    // an accepted item keeps the sequencer busy in the cycle after it is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous item still in work");

    // a result is never written over one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

    // the CORDIC and divider only finish while an item is in work
    a_units_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.cordic_done || w_stat.div_done) |-> !s_axis_tready)
        else $error("arithmetic unit finished while idle");
endmodule
`default_nettype wire
